@@ rtl/dkms_pkg.sv @@
// ============================================================================
// dkms_pkg
// Shared types, register indexes and a line-bit helper of the duplex key matrix scanner.
// ============================================================================
package dkms_pkg;

    localparam int unsigned LINE_W   = 8;
    localparam int unsigned KEY_W    = 16;
    localparam int unsigned RIDX_W   = 3;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELECT_SETTLE   = 2'd0,
        REG_UNSELECT_SETTLE = 2'd1,
        REG_ROW_PRESENT     = 2'd2,
        REG_COL_PRESENT     = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic {
        PHASE_ROW = 1'b0,
        PHASE_COL = 1'b1
    } t_phase;

    typedef enum logic {
        STEP_SELECT   = 1'b0,
        STEP_UNSELECT = 1'b1
    } t_step;

    typedef struct packed {
        logic              operation;
        logic [LINE_W-1:0] sense_row_levels;
        logic [LINE_W-1:0] sense_col_levels;
        logic [RIDX_W-1:0] read_row_index;
    } t_in_item;

    typedef struct packed {
        logic [LINE_W-1:0] drive_row_lines;
        logic [LINE_W-1:0] drive_col_lines;
        logic [KEY_W-1:0]  row_key_bits;
        logic              scan_done;
        logic              matrix_changed;
    } t_out_item;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [LINE_W-1:0]    data;
    } t_cfg_wr;

    // Level or mask bit of a line; lines past the mask width read as zero.
    function automatic logic line_bit(input logic [LINE_W-1:0] mask, input int idx);
        logic res;
        res = 1'b0;
        for (int k = 0; k < LINE_W; k++) begin
            if (k == idx) begin
                res = mask[k];
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/duplex_key_matrix_scanner_unit.sv @@
// ============================================================================
// duplex_key_matrix_scanner_unit
// Top level of the duplex key matrix scanner: item handshake and result register.
// ============================================================================
//
// Usage: each input item is either a tick, carrying the sensed row and column
// line levels of that moment, or a read of one row of the stable key matrix.
// Every accepted item yields exactly one result item carrying the line masks
// driven low at that moment, the requested row on a read, and the scan_done
// and matrix_changed flags on the tick that closes a full duplex pass.
// The result of an item accepted at one clock edge is registered there and
// valid right after it. Throughput is one item per cycle while the receiver
// does not stall; the figure is set by the single result register, behind
// which the sequencer step and the matrix update are combinational logic.
// Configuration is a plain write port (enable, index, data) and must only be
// used while the block is idle. The synchronous active-low reset restores the
// register defaults, puts the sequencer at the first row and clears both
// matrices; no result is pending after it. When the receiver stalls, the
// result stays held and the input side stalls only while a held result
// cannot leave in that same cycle.
//
module duplex_key_matrix_scanner_unit
    import dkms_pkg::*;
#(
    parameter int ROWS      = 8,
    parameter int HALF_COLS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LINE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item result;
    t_cfg_wr   cfg;
    logic      accept;

    // The input side waits only while a held result is itself stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    dkms_seq #(
        .ROWS      (ROWS),
        .HALF_COLS (HALF_COLS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (accept),
        .i_item   (i_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register needs no reset; it loads with every accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/dkms_seq.sv @@
// ============================================================================
// dkms_seq
// Scan sequencer, configuration registers and key matrices; computes the
// result of one item combinationally and commits state when it is accepted.
// ============================================================================
module dkms_seq
    import dkms_pkg::*;
#(
    parameter int ROWS      = 8,
    parameter int HALF_COLS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [LINE_W-1:0] r_sel_ticks, r_unsel_ticks, r_row_present, r_col_present;
    t_phase            r_phase, n_phase;
    t_step             r_step, n_step;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LINE_W-1:0] r_wait, n_wait;
    logic [KEY_W-1:0]  r_scratch [ROWS];
    logic [KEY_W-1:0]  n_scratch [ROWS];
    logic [KEY_W-1:0]  r_stable  [ROWS];
    logic [KEY_W-1:0]  n_stable  [ROWS];

    logic [KEY_W-1:0]  sampled [ROWS];
    logic [KEY_W-1:0]  row_keys, col_mask;
    logic [IDX_W:0]    col_pos;
    logic [IDX_W-1:0]  idx_inc;
    logic [LINE_W-1:0] wait_inc;
    logic              do_sample, do_advance, wraps, done, changed;

    assign idx_inc  = r_idx + IDX_W'(1);
    assign wait_inc = r_wait + LINE_W'(1);
    assign col_pos  = (IDX_W+1)'(HALF_COLS) + {1'b0, r_idx};

    always_comb begin
        row_keys = '0;
        for (int c = 0; c < HALF_COLS; c++) begin
            if (line_bit(r_col_present, c) && !line_bit(i_item.sense_col_levels, c)) begin
                row_keys[c] = 1'b1;
            end
        end
        col_mask = '0;
        if (!col_pos[IDX_W]) begin
            col_mask = KEY_W'(1) << col_pos[IDX_W-1:0];
        end
    end

    // Control decisions for a tick item.
    always_comb begin
        do_sample  = 1'b0;
        do_advance = 1'b0;
        n_step     = r_step;
        n_wait     = r_wait;
        if (i_step && i_item.operation == OP_TICK) begin
            if (r_step == STEP_SELECT) begin
                if (r_wait < r_sel_ticks) begin
                    n_wait = wait_inc;
                end else begin
                    do_sample = 1'b1;
                    if (r_unsel_ticks == '0) begin
                        do_advance = 1'b1;
                    end else begin
                        n_step = STEP_UNSELECT;
                        n_wait = '0;
                    end
                end
            end else begin
                n_wait = wait_inc;
                if (wait_inc >= r_unsel_ticks) begin
                    do_advance = 1'b1;
                end
            end
        end
        if (do_advance) begin
            n_step = STEP_SELECT;
            n_wait = '0;
        end
    end

    // Phase and line advance; a pass ends when the column phase wraps.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        wraps   = 1'b0;
        if (r_phase == PHASE_ROW) begin
            wraps = (32'(idx_inc) >= ROWS) || (idx_inc == '0);
        end else begin
            wraps = !((32'(idx_inc) < HALF_COLS) && (idx_inc != '0));
        end
        if (do_advance) begin
            n_idx = wraps ? '0 : idx_inc;
            if (wraps) begin
                n_phase = (r_phase == PHASE_ROW) ? PHASE_COL : PHASE_ROW;
            end
        end
        done = do_advance && wraps && (r_phase == PHASE_COL);
    end

    // Sampling into the scratch matrix and the end-of-pass copy.
    always_comb begin
        changed = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            sampled[r] = r_scratch[r];
            if (do_sample) begin
                if (r_phase == PHASE_ROW) begin
                    if (32'(r_idx) == r) begin
                        sampled[r] = r_scratch[r] | row_keys;
                    end
                end else if (line_bit(r_row_present, r)
                             && !line_bit(i_item.sense_row_levels, r)) begin
                    sampled[r] = r_scratch[r] | col_mask;
                end
            end
            if (sampled[r] != r_stable[r]) begin
                changed = 1'b1;
            end
            n_scratch[r] = done ? '0 : sampled[r];
            n_stable[r]  = done ? sampled[r] : r_stable[r];
        end
    end

    // Result: drive masks reflect the state before this item.
    always_comb begin
        o_result = '0;
        if (r_step == STEP_SELECT && !r_idx[IDX_W-1]) begin
            if (r_phase == PHASE_ROW) begin
                if (r_row_present[r_idx[2:0]]) begin
                    o_result.drive_row_lines = LINE_W'(1) << r_idx[2:0];
                end
            end else if (r_col_present[r_idx[2:0]]) begin
                o_result.drive_col_lines = LINE_W'(1) << r_idx[2:0];
            end
        end
        if (i_item.operation == OP_READ) begin
            for (int r = 0; r < ROWS; r++) begin
                if (int'(i_item.read_row_index) == r) begin
                    o_result.row_key_bits = r_stable[r];
                end
            end
        end
        o_result.scan_done      = done;
        o_result.matrix_changed = done && changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_ticks   <= LINE_W'(30);
            r_unsel_ticks <= LINE_W'(30);
            r_row_present <= '1;
            r_col_present <= '1;
            r_phase       <= PHASE_ROW;
            r_step        <= STEP_SELECT;
            r_idx         <= '0;
            r_wait        <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_scratch[r] <= '0;
                r_stable[r]  <= '0;
            end
        end else begin
            if (i_cfg.we) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    REG_SELECT_SETTLE:   r_sel_ticks   <= i_cfg.data;
                    REG_UNSELECT_SETTLE: r_unsel_ticks <= i_cfg.data;
                    REG_ROW_PRESENT:     r_row_present <= i_cfg.data;
                    REG_COL_PRESENT:     r_col_present <= i_cfg.data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_wait  <= n_wait;
            for (int r = 0; r < ROWS; r++) begin
                r_scratch[r] <= n_scratch[r];
                r_stable[r]  <= n_stable[r];
            end
        end
    end

endmodule

@@ test/duplex_key_matrix_scanner_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// duplex_key_matrix_scanner_unit_tb
// Self-checking bench for the duplex key matrix scanner. A scoreboard class
// carries its own model of the scan sequencer and of both key matrices.
// It predicts one result item for every accepted input item and compares
// each delivered result with the oldest prediction. The bench first drives a
// short directed run, then random phases under several register settings.
// Both handshake sides idle and stall at random.
// ============================================================================
module duplex_key_matrix_scanner_unit_tb;
    import dkms_pkg::*;

    localparam int N_ROWS     = 8;
    localparam int N_HALF     = 8;
    localparam int IDLE_LIMIT = 1000;

    // Scoreboard: predicts the scanner's result for every accepted item and
    // checks delivered results in order.
    class key_scan_scoreboard;
        logic [7:0]  sel_ticks, unsel_ticks, row_present, col_present;
        t_phase      scan_ph;
        logic [3:0]  line_idx;
        t_step       settle;
        logic [7:0]  wait_cnt;
        logic [15:0] scratch [N_ROWS];
        logic [15:0] stable  [N_ROWS];
        t_out_item   due_reports[$];
        int n_ticks, n_reads, n_passes, n_changed, n_checked, n_errors;

        function new();
            sel_ticks   = 8'd30;
            unsel_ticks = 8'd30;
            row_present = 8'hFF;
            col_present = 8'hFF;
            scan_ph     = PHASE_ROW;
            line_idx    = '0;
            settle      = STEP_SELECT;
            wait_cnt    = '0;
            for (int i = 0; i < N_ROWS; i++) begin
                scratch[i] = '0;
                stable[i]  = '0;
            end
            n_ticks = 0; n_reads = 0; n_passes = 0;
            n_changed = 0; n_checked = 0; n_errors = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [7:0] val);
            case (idx)
                REG_SELECT_SETTLE:   sel_ticks   = val;
                REG_UNSELECT_SETTLE: unsel_ticks = val;
                REG_ROW_PRESENT:     row_present = val;
                REG_COL_PRESENT:     col_present = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // Record the sensed levels of the line under visit into the scratch matrix.
        function void take_sample(logic [7:0] srow, logic [7:0] scol);
            if (scan_ph == PHASE_ROW) begin
                if (line_idx < N_ROWS) begin
                    for (int i = 0; i < N_HALF; i++) begin
                        if (col_present[i] && !scol[i]) scratch[line_idx[2:0]][i] = 1'b1;
                    end
                end
            end else begin
                for (int i = 0; i < N_ROWS; i++) begin
                    if (row_present[i] && !srow[i]) scratch[i][N_HALF + line_idx] = 1'b1;
                end
            end
        endfunction

        // Step to the next line; at the end of the column phase the pass closes.
        function void next_line(output logic done, output logic changed);
            done       = 1'b0;
            changed    = 1'b0;
            settle     = STEP_SELECT;
            wait_cnt   = '0;
            line_idx   = line_idx + 4'd1;
            if (scan_ph == PHASE_ROW) begin
                if (line_idx >= N_ROWS || line_idx == 0) begin
                    scan_ph  = PHASE_COL;
                    line_idx = '0;
                end
            end else if (line_idx >= N_HALF || line_idx == 0) begin
                scan_ph  = PHASE_ROW;
                line_idx = '0;
                done     = 1'b1;
                for (int i = 0; i < N_ROWS; i++) begin
                    if (scratch[i] != stable[i]) changed = 1'b1;
                    stable[i]  = scratch[i];
                    scratch[i] = '0;
                end
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            logic done, changed;
            r = '0;
            done = 1'b0;
            changed = 1'b0;
            // Drive masks reflect the line driven before this item takes effect.
            if (settle == STEP_SELECT && line_idx < 8) begin
                if (scan_ph == PHASE_ROW) begin
                    if (row_present[line_idx[2:0]]) r.drive_row_lines = 8'd1 << line_idx;
                end else if (col_present[line_idx[2:0]]) begin
                    r.drive_col_lines = 8'd1 << line_idx;
                end
            end
            if (it.operation == OP_READ) begin
                n_reads++;
                r.row_key_bits = stable[it.read_row_index];
            end else begin
                n_ticks++;
                if (settle == STEP_SELECT) begin
                    if (wait_cnt < sel_ticks) begin
                        wait_cnt = wait_cnt + 8'd1;
                    end else begin
                        take_sample(it.sense_row_levels, it.sense_col_levels);
                        if (unsel_ticks == 0) begin
                            next_line(done, changed);
                        end else begin
                            settle   = STEP_UNSELECT;
                            wait_cnt = '0;
                        end
                    end
                end else begin
                    wait_cnt = wait_cnt + 8'd1;
                    if (wait_cnt >= unsel_ticks) next_line(done, changed);
                end
            end
            r.scan_done      = done;
            r.matrix_changed = done & changed;
            if (done) n_passes++;
            if (done && changed) n_changed++;
            due_reports.push_back(r);
        endfunction

        function void flag(string msg);
            n_errors++;
            if (n_errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            n_checked++;
            if (due_reports.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing expected: %h", n_checked, got));
                return;
            end
            want = due_reports.pop_front();
            if (got.drive_row_lines != want.drive_row_lines ||
                got.drive_col_lines != want.drive_col_lines ||
                got.row_key_bits    != want.row_key_bits    ||
                got.scan_done       != want.scan_done       ||
                got.matrix_changed  != want.matrix_changed) begin
                flag($sformatf({"result %0d: expected row=%h col=%h keys=%h done=%b chg=%b,",
                                " got row=%h col=%h keys=%h done=%b chg=%b"},
                               n_checked, want.drive_row_lines, want.drive_col_lines,
                               want.row_key_bits, want.scan_done, want.matrix_changed,
                               got.drive_row_lines, got.drive_col_lines,
                               got.row_key_bits, got.scan_done, got.matrix_changed));
            end
        endfunction

        function void close_out();
            if (due_reports.size() != 0) begin
                flag($sformatf("%0d expected results never arrived", due_reports.size()));
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [7:0]       cfg_data;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_item;

    key_scan_scoreboard sb;
    int idle_cycles  = 0;
    int results_seen = 0;
    int n_settings   = 0;
    logic [7:0] held_row = 8'hFF;
    logic [7:0] held_col = 8'hFF;

    duplex_key_matrix_scanner_unit #(
        .ROWS      (N_ROWS),
        .HALF_COLS (N_HALF)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    // Monitor: every handshake is observed at the rising edge, before the
    // block's own registers update. Results are checked before the input of
    // the same edge is noted, since a result always belongs to an older item.
    always @(posedge clk) begin
        logic took_in, took_out;
        took_in  = in_valid && !in_stall;
        took_out = out_valid && !out_stall;
        if (rst_n) begin
            if (took_out) begin
                sb.check_result(out_item);
                results_seen++;
            end
            if (took_in) sb.note_input(in_item);
            if (took_in || took_out) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Receiver: the stall pattern picks a new random mode at regular intervals. Once, after a
    // few hundred results, the receiver holds off for a long stretch so that
    // the result register fills and the input side stalls.
    initial begin
        int mode;
        int cyc;
        bit long_hold_done;
        mode = 0;
        cyc = 0;
        long_hold_done = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1;
                out_stall = 1'b1;
                repeat (120) @(negedge clk);
                out_stall = 1'b0;
            end else begin
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    2: out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = cyc[0];
                endcase
            end
        end
    end

    // Watchdog: the run is dead if nothing moves on either side for too long.
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(negedge clk);
        $display("TIMEOUT: no handshake for %0d cycles", IDLE_LIMIT);
        $display("duplex_key_matrix_scanner_unit_tb NOT OK");
        $finish;
    end

    function automatic t_in_item mk_item(t_op op, logic [7:0] srow, logic [7:0] scol,
                                         logic [2:0] ridx);
        t_in_item it;
        it.operation        = op;
        it.sense_row_levels = srow;
        it.sense_col_levels = scol;
        it.read_row_index   = ridx;
        return it;
    endfunction

    // Random item: mostly the held key pattern so that passes repeat and the
    // changed flag goes both ways, with some noise and a share of reads.
    function automatic t_in_item rand_item(int read_pct);
        if ($urandom_range(0, 39) == 0) begin
            held_row = 8'($urandom_range(0, 255));
            held_col = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < read_pct) begin
            return mk_item(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           3'($urandom_range(0, 7)));
        end
        if ($urandom_range(0, 9) == 0) begin
            return mk_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           3'($urandom_range(0, 7)));
        end
        return mk_item(OP_TICK, held_row, held_col, 3'($urandom_range(0, 7)));
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(t_in_item it);
        @(negedge clk);
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has been delivered.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write all four registers while the block is idle.
    task automatic set_regs(logic [7:0] sel, logic [7:0] unsel, logic [7:0] rmask,
                            logic [7:0] cmask);
        t_cfg_reg   idx [4];
        logic [7:0] val [4];
        idx = '{REG_SELECT_SETTLE, REG_UNSELECT_SETTLE, REG_ROW_PRESENT, REG_COL_PRESENT};
        val = '{sel, unsel, rmask, cmask};
        for (int k = 0; k < 4; k++) begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = idx[k];
            cfg_data  = val[k];
            @(posedge clk);
            sb.write_reg(idx[k], val[k]);
        end
        @(negedge clk);
        cfg_we = 1'b0;
        n_settings++;
    endtask

    // One random phase: drain, reprogram, then bursts of items with random gaps.
    task automatic run_phase(logic [7:0] sel, logic [7:0] unsel, logic [7:0] rmask,
                             logic [7:0] cmask, int count, int read_pct);
        int burst_left;
        bit gaps_on;
        burst_left = 0;
        gaps_on = 1;
        drain();
        set_regs(sel, unsel, rmask, cmask);
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                if (gaps_on) begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    repeat ($urandom_range(0, 5)) @(negedge clk);
                end
                burst_left = $urandom_range(1, 30);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            send_item(rand_item(read_pct));
            burst_left--;
        end
    endtask

    initial begin
        sb = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SELECT_SETTLE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reads and extreme levels under the reset settings, where the
        // first row is driven but no sample is due yet.
        send_item(mk_item(OP_READ, 8'h00, 8'hFF, 3'd0));
        send_item(mk_item(OP_READ, 8'hFF, 8'h00, 3'd7));
        send_item(mk_item(OP_TICK, 8'h00, 8'h00, 3'd0));
        send_item(mk_item(OP_TICK, 8'hFF, 8'hFF, 3'd7));

        // With no settle time each tick visits one line, so sixteen ticks with
        // every line pulled low close a pass with every key pressed. The scan
        // restarts mid-wait, so the lowered select limit ends that wait at once.
        drain();
        set_regs(8'd0, 8'd0, 8'hFF, 8'hFF);
        repeat (16) send_item(mk_item(OP_TICK, 8'h00, 8'h00, 3'd0));
        send_item(mk_item(OP_READ, 8'hFF, 8'hFF, 3'd0));
        send_item(mk_item(OP_READ, 8'hFF, 8'hFF, 3'd7));

        // Random phases, the long settle extremes among them.
        run_phase(8'd0,   8'd0,   8'hFF, 8'hFF, 200, 20);
        run_phase(8'd1,   8'd0,   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  180, 20);
        run_phase(8'd0,   8'd1,   8'h00, 8'h00, 100, 20);
        run_phase(8'd2,   8'd3,   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  180, 20);
        run_phase(8'd255, 8'd0,   8'hFF, 8'hFF, 400, 4);
        run_phase(8'd0,   8'd255, 8'hA5, 8'h5A, 400, 4);
        run_phase(8'd1,   8'd1,   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  180, 20);

        drain();
        repeat (4) @(negedge clk);
        sb.close_out();

        $display("Checked %0d results from %0d ticks and %0d reads under %0d settings.",
                 sb.n_checked, sb.n_ticks, sb.n_reads, n_settings);
        $display("Saw %0d completed scan passes, %0d of them with a changed matrix.",
                 sb.n_passes, sb.n_changed);
        if (sb.n_errors == 0) begin
            $display("duplex_key_matrix_scanner_unit_tb OK");
        end else begin
            $display("%0d mismatches in total", sb.n_errors);
            $display("duplex_key_matrix_scanner_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dkms_pkg.sv
rtl/dkms_seq.sv
rtl/duplex_key_matrix_scanner_unit.sv
test/duplex_key_matrix_scanner_unit_tb.sv
